### hdl/first_fit_pool_allocator_core_assert.svh
// Assertion macros for the first-fit pool allocator.
// Used by the top level; needs nothing else.
`ifndef FIRST_FIT_POOL_ALLOCATOR_CORE_ASSERT_SVH
`define FIRST_FIT_POOL_ALLOCATOR_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FFPA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FFPA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/ffpa_pkg.sv
// Shared types, codes and constants for the first-fit pool allocator.
// Used by every module of the block but ffpa_ram; depends on nothing.
package ffpa_pkg;

  // Default sizing of the pool and of the two tables.
  localparam int POOL_BYTES_DEF = 32768;
  localparam int MAX_HOLES_DEF  = 64;
  localparam int MAX_BLOCKS_DEF = 64;

  // Fixed field widths.
  localparam int ADDR_W   = 15;
  localparam int SIZE_W   = 16;
  localparam int FREE_W   = 16;
  localparam int USED_W   = 7;

  // Request codes.
  typedef enum logic [1:0] {
    FN_ALLOC   = 2'd0,
    FN_FREE    = 2'd1,
    FN_REALLOC = 2'd2,
    FN_NOP     = 2'd3
  } func_t;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EXCEEDS  = 3'd1,
    ST_NOFIT    = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  // One request.
  typedef struct packed {
    func_t              func;
    logic [ADDR_W-1:0]  address;
    logic [SIZE_W-1:0]  size;
  } in_item_t;

  // One result.
  typedef struct packed {
    logic [ADDR_W-1:0]  block_address;
    status_t            status;
    logic [FREE_W-1:0]  free_bytes;
    logic [USED_W-1:0]  used_blocks;
  } out_item_t;

  // Controller states.
  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_DISPATCH,
    S_ALLOC_CHK,
    S_LSCAN,
    S_FREE_CHK,
    S_HSCAN,
    S_SSCAN,
    S_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    init_hole;
    logic    accept;
    logic    set_status;
    status_t status_code;
    logic    lscan_start;
    logic    lscan_step;
    logic    free_commit;
    logic    hscan_start;
    logic    hscan_step;
    logic    sscan_start;
    logic    sscan_step;
    logic    alloc_commit;
    logic    load_out;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    func_t func;
    logic  exceeds;
    logic  lscan_hit;
    logic  lscan_end;
    logic  holes_full;
    logic  hscan_hit;
    logic  hscan_end;
    logic  sscan_hit;
    logic  sscan_end;
  } dp_sts_t;

endpackage

### hdl/first_fit_pool_allocator_core.sv
// First-fit pool allocator: top level joining controller and datapath.
// Depends on ffpa_pkg, ffpa_ctrl, ffpa_dp, ffpa_ram and the assertion header.
//
// Usage: each request on in_data (allocate, free, reallocate, or no-op) is
// transferred when in_valid is high and in_stall is low. The block works on
// one request at a time and returns exactly one result on out_data, which
// transfers when out_valid is high and out_stall is low.
// Steps: allocate runs a hole scan, then a free-slot scan; free runs a
// live-table scan; reallocate runs the free, then the allocation.
// The next request can be taken in the cycle after the result is loaded.
// The hole and live-table scans read one entry per cycle through the
// single registered read port of the hole RAM and of the live RAM.
// Reset: synchronous, active low. The cycle after reset writes the initial
// whole-pool hole, so in_stall stays high for that one cycle.
// The result sits in an output register: a stalled result holds steady
// while the next request is taken and processed; that request's result
// waits in the datapath registers until the output register frees up.
`include "first_fit_pool_allocator_core_assert.svh"

module first_fit_pool_allocator_core #(
  parameter int POOL_BYTES = ffpa_pkg::POOL_BYTES_DEF,
  parameter int MAX_HOLES  = ffpa_pkg::MAX_HOLES_DEF,
  parameter int MAX_BLOCKS = ffpa_pkg::MAX_BLOCKS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ffpa_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ffpa_pkg::out_item_t out_data
);

  ffpa_pkg::ctl_cmd_t cmd;
  ffpa_pkg::dp_sts_t  sts;

  // Sequencing of each request.
  ffpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Tables, counters and result register.
  ffpa_dp #(
    .POOL_BYTES (POOL_BYTES),
    .MAX_HOLES  (MAX_HOLES),
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_data  (in_data),
    .out_data (out_data)
  );

  // A transfer in starts work, so the block is busy on the next cycle.
  `FFPA_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall, "request taken while idle did not start work")

  // A refused request never reports a block address.
  `FFPA_ASSERT_SAME(a_addr_zero_on_error, clk, rst_n, out_valid && (out_data.status != ffpa_pkg::ST_OK), out_data.block_address == '0, "nonzero address on refused request")

  // A new result only appears after the block was busy with a request.
  `FFPA_ASSERT_SAME(a_result_from_work, clk, rst_n, $rose(out_valid), $past(in_stall), "result appeared without a request in progress")

endmodule

### hdl/ffpa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the hole table and the live-block table; no dependencies.
module ffpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### hdl/ffpa_ctrl.sv
// Controller state machine of the first-fit pool allocator.
// Depends on ffpa_pkg; drives the datapath through ctl_cmd_t.
module ffpa_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  ffpa_pkg::dp_sts_t  sts,
  output ffpa_pkg::ctl_cmd_t cmd
);

  ffpa_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;

  // State and output-valid registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ffpa_pkg::S_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ffpa_pkg::S_INIT: begin
        cmd.init_hole = 1'b1;
        state_nxt     = ffpa_pkg::S_IDLE;
      end
      ffpa_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ffpa_pkg::S_DISPATCH;
        end
      end
      ffpa_pkg::S_DISPATCH: begin
        case (sts.func)
          ffpa_pkg::FN_ALLOC: begin
            state_nxt = ffpa_pkg::S_ALLOC_CHK;
          end
          ffpa_pkg::FN_FREE, ffpa_pkg::FN_REALLOC: begin
            cmd.lscan_start = 1'b1;
            state_nxt       = ffpa_pkg::S_LSCAN;
          end
          default: begin
            state_nxt = ffpa_pkg::S_DONE;
          end
        endcase
      end
      ffpa_pkg::S_ALLOC_CHK: begin
        if (sts.exceeds) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = ffpa_pkg::ST_EXCEEDS;
          state_nxt       = ffpa_pkg::S_DONE;
        end else begin
          cmd.hscan_start = 1'b1;
          state_nxt       = ffpa_pkg::S_HSCAN;
        end
      end
      ffpa_pkg::S_LSCAN: begin
        cmd.lscan_step = 1'b1;
        if (sts.lscan_hit) begin
          state_nxt = ffpa_pkg::S_FREE_CHK;
        end else if (sts.lscan_end) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = ffpa_pkg::ST_NOTFOUND;
          state_nxt       = ffpa_pkg::S_DONE;
        end
      end
      ffpa_pkg::S_FREE_CHK: begin
        if (sts.holes_full) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = ffpa_pkg::ST_FULL;
          state_nxt       = ffpa_pkg::S_DONE;
        end else begin
          // A reallocate goes on to the allocation once the free is done.
          cmd.free_commit = 1'b1;
          state_nxt       = (sts.func == ffpa_pkg::FN_REALLOC) ?
                            ffpa_pkg::S_ALLOC_CHK : ffpa_pkg::S_DONE;
        end
      end
      ffpa_pkg::S_HSCAN: begin
        cmd.hscan_step = 1'b1;
        if (sts.hscan_hit) begin
          cmd.sscan_start = 1'b1;
          state_nxt       = ffpa_pkg::S_SSCAN;
        end else if (sts.hscan_end) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = ffpa_pkg::ST_NOFIT;
          state_nxt       = ffpa_pkg::S_DONE;
        end
      end
      ffpa_pkg::S_SSCAN: begin
        if (sts.sscan_hit) begin
          cmd.alloc_commit = 1'b1;
          state_nxt        = ffpa_pkg::S_DONE;
        end else if (sts.sscan_end) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = ffpa_pkg::ST_FULL;
          state_nxt       = ffpa_pkg::S_DONE;
        end else begin
          cmd.sscan_step = 1'b1;
        end
      end
      ffpa_pkg::S_DONE: begin
        // Load the result once the output register is free or being drained.
        if (!out_valid_r || !out_stall) begin
          cmd.load_out = 1'b1;
          state_nxt    = ffpa_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = ffpa_pkg::S_INIT;
      end
    endcase
  end

  // Output register occupancy.
  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign in_stall  = (state_r != ffpa_pkg::S_IDLE);
  assign out_valid = out_valid_r;

endmodule

### hdl/ffpa_dp.sv
// Datapath of the first-fit pool allocator: tables, counters, scans, result.
// Depends on ffpa_pkg and ffpa_ram; commanded by ffpa_ctrl.
module ffpa_dp #(
  parameter int POOL_BYTES = ffpa_pkg::POOL_BYTES_DEF,
  parameter int MAX_HOLES  = ffpa_pkg::MAX_HOLES_DEF,
  parameter int MAX_BLOCKS = ffpa_pkg::MAX_BLOCKS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ffpa_pkg::ctl_cmd_t  cmd,
  output ffpa_pkg::dp_sts_t   sts,
  input  ffpa_pkg::in_item_t  in_data,
  output ffpa_pkg::out_item_t out_data
);

  localparam int AW  = ffpa_pkg::ADDR_W;
  localparam int LW  = $clog2(POOL_BYTES + 1);
  localparam int CW  = (LW > ffpa_pkg::SIZE_W) ? LW : ffpa_pkg::SIZE_W;
  localparam int EW  = AW + LW;
  localparam int HIW = $clog2(MAX_HOLES);
  localparam int HCW = $clog2(MAX_HOLES + 1);
  localparam int BIW = $clog2(MAX_BLOCKS);
  localparam int BCW = $clog2(MAX_BLOCKS + 1);

  // Request and result registers.
  ffpa_pkg::in_item_t  req_r;
  ffpa_pkg::status_t   status_r;
  logic [AW-1:0]       res_addr_r;
  ffpa_pkg::out_item_t out_r;

  // Allocator bookkeeping.
  logic [HCW-1:0]        hole_count_r;
  logic [LW-1:0]         bytes_free_r;
  logic [BCW-1:0]        live_count_r;
  logic [MAX_BLOCKS-1:0] live_valid_r;

  // Hole scan.
  logic [HCW-1:0] hrd_r;
  logic           hchk_vld_r;
  logic [HIW-1:0] hchk_idx_r;
  logic [HIW-1:0] hit_idx_r;
  logic [AW-1:0]  hit_start_r;
  logic [LW-1:0]  hit_len_r;

  // Live-table scan.
  logic [BCW-1:0] lrd_r;
  logic           lchk_vld_r;
  logic [BIW-1:0] lchk_idx_r;
  logic [BIW-1:0] fnd_idx_r;
  logic [AW-1:0]  fnd_addr_r;
  logic [LW-1:0]  fnd_len_r;

  // Free-slot scan.
  logic [BCW-1:0] sptr_r;

  // Memory ports.
  logic           hole_wr_en;
  logic [HIW-1:0] hole_wr_addr;
  logic [EW-1:0]  hole_wr_data;
  logic [EW-1:0]  hole_rd_data;
  logic [EW-1:0]  live_rd_data;

  logic [AW-1:0]  h_start;
  logic [LW-1:0]  h_len;
  logic [AW-1:0]  l_addr;
  logic [LW-1:0]  l_len;
  logic [LW-1:0]  size_lw;
  logic [BIW-1:0] slot_idx;
  logic           hscan_hit;
  logic           lscan_hit;
  logic           sscan_hit;

  // Table entries are packed as {start or address, length}.
  assign h_start  = hole_rd_data[LW +: AW];
  assign h_len    = hole_rd_data[LW-1:0];
  assign l_addr   = live_rd_data[LW +: AW];
  assign l_len    = live_rd_data[LW-1:0];
  assign size_lw  = LW'(req_r.size);
  assign slot_idx = sptr_r[BIW-1:0];

  // Scan matches.
  assign hscan_hit = hchk_vld_r && (h_len != '0) && (CW'(req_r.size) <= CW'(h_len));
  assign lscan_hit = lchk_vld_r && live_valid_r[lchk_idx_r] && (l_addr == req_r.address);
  assign sscan_hit = (sptr_r != BCW'(MAX_BLOCKS)) && !live_valid_r[slot_idx];

  // Status toward the controller.
  always_comb begin
    sts            = '0;
    sts.func       = req_r.func;
    sts.exceeds    = CW'(req_r.size) > CW'(bytes_free_r);
    sts.lscan_hit  = lscan_hit;
    sts.lscan_end  = !lchk_vld_r && (lrd_r == BCW'(MAX_BLOCKS));
    sts.holes_full = (hole_count_r == HCW'(MAX_HOLES));
    sts.hscan_hit  = hscan_hit;
    sts.hscan_end  = !hchk_vld_r && (hrd_r >= hole_count_r);
    sts.sscan_hit  = sscan_hit;
    sts.sscan_end  = (sptr_r == BCW'(MAX_BLOCKS));
  end

  // Hole table write: initial hole, released block, or trimmed hole.
  always_comb begin
    hole_wr_en   = 1'b0;
    hole_wr_addr = '0;
    hole_wr_data = '0;
    if (cmd.init_hole) begin
      hole_wr_en   = 1'b1;
      hole_wr_data = {{AW{1'b0}}, LW'(POOL_BYTES)};
    end else if (cmd.free_commit) begin
      hole_wr_en   = 1'b1;
      hole_wr_addr = hole_count_r[HIW-1:0];
      hole_wr_data = {fnd_addr_r, fnd_len_r};
    end else if (cmd.alloc_commit) begin
      hole_wr_en   = 1'b1;
      hole_wr_addr = hit_idx_r;
      hole_wr_data = {hit_start_r + req_r.size[AW-1:0], hit_len_r - size_lw};
    end
  end

  ffpa_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_HOLES)
  ) u_hole_ram (
    .clk     (clk),
    .wr_en   (hole_wr_en),
    .wr_addr (hole_wr_addr),
    .wr_data (hole_wr_data),
    .rd_addr (hrd_r[HIW-1:0]),
    .rd_data (hole_rd_data)
  );

  ffpa_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_BLOCKS)
  ) u_live_ram (
    .clk     (clk),
    .wr_en   (cmd.alloc_commit),
    .wr_addr (slot_idx),
    .wr_data ({hit_start_r, size_lw}),
    .rd_addr (lrd_r[BIW-1:0]),
    .rd_data (live_rd_data)
  );

  // Bookkeeping counters, valid bits and scan pointers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hole_count_r <= HCW'(1);
      bytes_free_r <= LW'(POOL_BYTES);
      live_count_r <= '0;
      live_valid_r <= '0;
      hrd_r        <= '0;
      hchk_vld_r   <= 1'b0;
      lrd_r        <= '0;
      lchk_vld_r   <= 1'b0;
      sptr_r       <= '0;
    end else begin
      if (cmd.free_commit) begin
        hole_count_r            <= hole_count_r + HCW'(1);
        live_valid_r[fnd_idx_r] <= 1'b0;
        live_count_r            <= live_count_r - BCW'(1);
        bytes_free_r            <= bytes_free_r + fnd_len_r;
      end
      if (cmd.alloc_commit) begin
        live_valid_r[slot_idx] <= 1'b1;
        live_count_r           <= live_count_r + BCW'(1);
        bytes_free_r           <= bytes_free_r - size_lw;
      end
      // Hole scan issues one read a cycle while entries remain.
      if (cmd.hscan_start) begin
        hrd_r      <= '0;
        hchk_vld_r <= 1'b0;
      end else if (cmd.hscan_step) begin
        if (hrd_r < hole_count_r) begin
          hrd_r      <= hrd_r + HCW'(1);
          hchk_vld_r <= 1'b1;
        end else begin
          hchk_vld_r <= 1'b0;
        end
      end
      // Live scan covers the whole table.
      if (cmd.lscan_start) begin
        lrd_r      <= '0;
        lchk_vld_r <= 1'b0;
      end else if (cmd.lscan_step) begin
        if (lrd_r != BCW'(MAX_BLOCKS)) begin
          lrd_r      <= lrd_r + BCW'(1);
          lchk_vld_r <= 1'b1;
        end else begin
          lchk_vld_r <= 1'b0;
        end
      end
      // Free-slot scan walks the valid bits.
      if (cmd.sscan_start) begin
        sptr_r <= '0;
      end else if (cmd.sscan_step) begin
        sptr_r <= sptr_r + BCW'(1);
      end
    end
  end

  // Request capture, scan results and the result register.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_r      <= in_data;
      status_r   <= ffpa_pkg::ST_OK;
      res_addr_r <= '0;
    end
    if (cmd.set_status) begin
      status_r <= cmd.status_code;
    end
    if (cmd.alloc_commit) begin
      res_addr_r <= hit_start_r;
    end
    if (cmd.hscan_step) begin
      hchk_idx_r <= hrd_r[HIW-1:0];
    end
    if (cmd.hscan_step && hscan_hit) begin
      hit_idx_r   <= hchk_idx_r;
      hit_start_r <= h_start;
      hit_len_r   <= h_len;
    end
    if (cmd.lscan_step) begin
      lchk_idx_r <= lrd_r[BIW-1:0];
    end
    if (cmd.lscan_step && lscan_hit) begin
      fnd_idx_r  <= lchk_idx_r;
      fnd_addr_r <= l_addr;
      fnd_len_r  <= l_len;
    end
    if (cmd.load_out) begin
      out_r.block_address <= res_addr_r;
      out_r.status        <= status_r;
      out_r.free_bytes    <= ffpa_pkg::FREE_W'(bytes_free_r);
      out_r.used_blocks   <= ffpa_pkg::USED_W'(live_count_r);
    end
  end

  assign out_data = out_r;

endmodule

### tb/sv/first_fit_pool_allocator_core_tb.sv
// Self-checking testbench for the first-fit pool allocator core.
// Depends on ffpa_pkg and first_fit_pool_allocator_core; holds its own allocator model.
`timescale 1ns / 1ps

module first_fit_pool_allocator_core_tb;
  import ffpa_pkg::*;

  localparam int POOL_BYTES  = POOL_BYTES_DEF;
  localparam int MAX_HOLES   = MAX_HOLES_DEF;
  localparam int MAX_BLOCKS  = MAX_BLOCKS_DEF;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_WAIT  = 300;
  localparam int HOLD_CYCLES = 1500;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  // Allocator model: hole table, live-block table and counters.
  logic [SIZE_W-1:0] hole_base [MAX_HOLES];
  logic [SIZE_W-1:0] hole_len  [MAX_HOLES];
  logic [6:0]        hole_cnt;
  logic [ADDR_W-1:0] blk_base  [MAX_BLOCKS];
  logic [SIZE_W-1:0] blk_len   [MAX_BLOCKS];
  bit                blk_live  [MAX_BLOCKS];
  logic [FREE_W-1:0] pool_free;
  logic [USED_W-1:0] blk_cnt;

  // Results the model predicts, oldest first.
  out_item_t pending_results [$];

  int mismatch_count;
  int sent_count;
  int checked_count;
  int cycle_count;
  int status_seen [5];
  int tx_idle_pct;
  int rx_idle_pct;
  int hold_requests;
  int hold_seen;
  int hold_left;

  first_fit_pool_allocator_core uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Safety net against a hung block.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results pending.", cycle_count,
               pending_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    $display("[%0t] mismatch: %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  function automatic void reset_model();
    foreach (hole_base[h]) begin
      hole_base[h] = '0;
      hole_len[h]  = '0;
    end
    foreach (blk_live[s]) begin
      blk_base[s] = '0;
      blk_len[s]  = '0;
      blk_live[s] = 1'b0;
    end
    hole_len[0] = SIZE_W'(POOL_BYTES);
    hole_cnt    = 7'd1;
    pool_free   = FREE_W'(POOL_BYTES);
    blk_cnt     = '0;
  endfunction

  // Carve a block from the front of the first nonempty hole that fits.
  function automatic status_t carve_block(input logic [SIZE_W-1:0] size,
                                          output logic [ADDR_W-1:0] addr);
    int gap;
    int slot;
    gap  = -1;
    slot = -1;
    addr = '0;
    if (size > pool_free) return ST_EXCEEDS;
    for (int h = 0; h < hole_cnt && h < MAX_HOLES; h++) begin
      if (hole_len[h] != 0 && size <= hole_len[h]) begin
        gap = h;
        break;
      end
    end
    if (gap < 0) return ST_NOFIT;
    for (int s = 0; s < MAX_BLOCKS; s++) begin
      if (!blk_live[s]) begin
        slot = s;
        break;
      end
    end
    if (slot < 0) return ST_FULL;
    addr           = hole_base[gap][ADDR_W-1:0];
    blk_base[slot] = hole_base[gap][ADDR_W-1:0];
    blk_len[slot]  = size;
    blk_live[slot] = 1'b1;
    blk_cnt++;
    hole_base[gap] += size;
    hole_len[gap]  -= size;
    pool_free      -= size;
    return ST_OK;
  endfunction

  // Release the lowest live block at this address as a new hole.
  function automatic status_t release_block(input logic [ADDR_W-1:0] address);
    int slot;
    slot = -1;
    for (int s = 0; s < MAX_BLOCKS; s++) begin
      if (blk_live[s] && blk_base[s] == address) begin
        slot = s;
        break;
      end
    end
    if (slot < 0) return ST_NOTFOUND;
    if (hole_cnt >= MAX_HOLES) return ST_FULL;
    hole_base[hole_cnt] = {1'b0, blk_base[slot]};
    hole_len[hole_cnt]  = blk_len[slot];
    hole_cnt++;
    blk_live[slot] = 1'b0;
    blk_cnt--;
    pool_free += blk_len[slot];
    return ST_OK;
  endfunction

  // Advance the model by one request and return the result it predicts.
  function automatic out_item_t apply_request(input in_item_t req);
    out_item_t         res;
    logic [ADDR_W-1:0] addr;
    status_t           st;
    addr = '0;
    st   = ST_OK;
    case (req.func)
      FN_ALLOC: st = carve_block(req.size, addr);
      FN_FREE:  st = release_block(req.address);
      FN_REALLOC: begin
        st = release_block(req.address);
        if (st == ST_OK) st = carve_block(req.size, addr);
      end
      default: ;
    endcase
    if (st != ST_OK) addr = '0;
    res.block_address = addr;
    res.status        = st;
    res.free_bytes    = pool_free;
    res.used_blocks   = blk_cnt;
    status_seen[int'(st)]++;
    return res;
  endfunction

  // Pick the address of a random live block, if there is one.
  function automatic bit pick_live(output logic [ADDR_W-1:0] addr);
    int pick;
    addr = '0;
    if (blk_cnt == 0) return 1'b0;
    pick = $urandom_range(0, blk_cnt - 1);
    foreach (blk_live[s]) begin
      if (blk_live[s]) begin
        if (pick == 0) begin
          addr = blk_base[s];
          return 1'b1;
        end
        pick--;
      end
    end
    return 1'b0;
  endfunction

  // Mostly small sizes, with zero, wide random values and near-pool sizes mixed in.
  function automatic logic [SIZE_W-1:0] random_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return '0;
    if (r < 10) return SIZE_W'($urandom);
    if (r < 14) return SIZE_W'($urandom_range(16384, 32768));
    return SIZE_W'($urandom_range(1, 512));
  endfunction

  // One random request. Frees aimed at live blocks are rationed so that the
  // hole table, which never shrinks, fills up over the run instead of early.
  function automatic in_item_t random_request(input int left);
    in_item_t          req;
    logic [ADDR_W-1:0] live_addr;
    int                roll;
    int                holes_left;
    bit                aim;
    roll        = $urandom_range(0, 99);
    holes_left  = MAX_HOLES - hole_cnt;
    aim         = (holes_left == 0) ? ($urandom_range(0, 1) == 1)
                                    : ($urandom_range(1, left) <= 4 * holes_left);
    req.address = ADDR_W'($urandom);
    req.size    = random_size();
    if (roll < 40) begin
      req.func = FN_ALLOC;
    end else if (roll < 70) begin
      req.func = FN_FREE;
    end else if (roll < 92) begin
      req.func = FN_REALLOC;
    end else if (roll < 96) begin
      req.func = FN_NOP;
    end else begin
      req.func = func_t'($urandom_range(0, 3));
      req.size = SIZE_W'($urandom);
    end
    if ((req.func == FN_FREE || req.func == FN_REALLOC) && aim && pick_live(live_addr)) begin
      req.address = live_addr;
    end
    return req;
  endfunction

  // Offer one request, idling first at the current rate, and wait for the transfer.
  task automatic send_request(input in_item_t req);
    in_item_t noise;
    @(negedge clk);
    while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      noise    = {1'b0, $urandom};
      in_valid <= 1'b0;
      in_data  <= noise;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall !== 1'b0);
    pending_results.push_back(apply_request(req));
    sent_count++;
  endtask

  task automatic send_fields(input func_t func, input logic [ADDR_W-1:0] address,
                             input logic [SIZE_W-1:0] size);
    in_item_t req;
    req.func    = func;
    req.address = address;
    req.size    = size;
    send_request(req);
  endtask

  // Receiver: random stalls, plus long hold-offs on request.
  always @(negedge clk) begin
    if (hold_requests != hold_seen) begin
      hold_seen = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (rx_idle_pct != 0) && ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  // Compare each result transfer with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending, status", int'(out_data.status), -1);
      end else begin
        out_item_t want;
        want = pending_results.pop_front();
        checked_count++;
        if (out_data.block_address !== want.block_address)
          report_mismatch("block_address", out_data.block_address, want.block_address);
        if (out_data.status !== want.status)
          report_mismatch("status", int'(out_data.status), int'(want.status));
        if (out_data.free_bytes !== want.free_bytes)
          report_mismatch("free_bytes", out_data.free_bytes, want.free_bytes);
        if (out_data.used_blocks !== want.used_blocks)
          report_mismatch("used_blocks", out_data.used_blocks, want.used_blocks);
      end
    end
  end

  // Field extremes, every request code and each corner of the hole scan.
  task automatic test_directed();
    tx_idle_pct = 37;
    rx_idle_pct = 66;
    send_fields(FN_NOP, '1, '1);
    send_fields(FN_ALLOC, '1, 16'd0);        // zero-length block at the pool start
    send_fields(FN_ALLOC, '0, 16'd16);       // same address as the zero-length block
    send_fields(FN_FREE, '0, '1);            // lowest matching slot goes first
    send_fields(FN_FREE, '0, '0);
    send_fields(FN_FREE, '0, '0);            // nothing live there any more
    send_fields(FN_ALLOC, '0, 16'hFFFF);     // more than the free bytes
    send_fields(FN_ALLOC, '0, 16'h8000);     // fits the byte count but no single hole
    send_fields(FN_ALLOC, '0, 16'd16);
    send_fields(FN_ALLOC, '0, 16'd32736);    // empties the first hole
    send_fields(FN_ALLOC, '0, 16'd16);       // skips empty holes to a freed one
    send_fields(FN_ALLOC, '0, 16'd0);        // empty holes never fit, even size zero
    send_fields(FN_REALLOC, 15'd32, 16'hFFFF);  // free lands, allocation refused
    send_fields(FN_REALLOC, 15'd16, 16'd16);
    send_fields(FN_REALLOC, 15'h4321, 16'd8);
    send_fields(FN_FREE, 15'h7FFF, 16'd0);
    send_fields(FN_ALLOC, 15'h5555, 16'd1);
    send_fields(FN_ALLOC, 15'h2AAA, 16'h7FFF);
  endtask

  // Fill the live-block table, then allocate into it while full.
  task automatic test_live_table_full();
    logic [ADDR_W-1:0] addr;
    int                guard;
    guard = 0;
    while (blk_cnt < MAX_BLOCKS && guard < 200) begin
      send_fields(FN_ALLOC, ADDR_W'($urandom), SIZE_W'($urandom_range(1, 48)));
      guard++;
    end
    send_fields(FN_ALLOC, '0, 16'd1);
    send_fields(FN_ALLOC, '1, 16'd0);
    repeat (3) begin
      if (pick_live(addr)) send_fields(FN_FREE, addr, SIZE_W'($urandom));
    end
  endtask

  // Hold the result side off for a long stretch while requests keep coming.
  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_requests++;
    repeat (20) send_request(random_request(400));
  endtask

  task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int count);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int k = 0; k < count; k++) send_request(random_request(count - k));
  endtask

  // Use up the hole table, then free and reallocate a live block.
  task automatic test_hole_table_full();
    logic [ADDR_W-1:0] addr;
    int                guard;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    guard       = 0;
    while (hole_cnt < MAX_HOLES && guard < 300) begin
      if (pick_live(addr)) send_fields(FN_FREE, addr, '0);
      else send_fields(FN_ALLOC, '0, 16'd8);
      guard++;
    end
    if (!pick_live(addr)) send_fields(FN_ALLOC, '0, 16'd1);
    if (pick_live(addr)) begin
      send_fields(FN_FREE, addr, '0);
      send_fields(FN_REALLOC, addr, 16'd1);
    end
    send_fields(FN_ALLOC, '0, 16'd4);
  endtask

  // Main sequence.
  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    out_stall     = 1'b0;
    tx_idle_pct   = 0;
    rx_idle_pct   = 0;
    hold_requests = 0;
    hold_seen     = 0;
    hold_left     = 0;
    reset_model();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_live_table_full();
    test_random_traffic(37, 66, 350);
    test_backpressure();
    test_random_traffic(66, 37, 350);
    test_random_traffic(0, 0, 350);
    test_hole_table_full();

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch("results still pending at end", 0, pending_results.size());

    $display("Sent %0d requests and checked %0d results over %0d cycles.",
             sent_count, checked_count, cycle_count);
    $display("Outcomes: ok %0d, over free bytes %0d, no fit %0d, not found %0d, full %0d.",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
